// ----- sv/mwg_pkg.sv -----
// Package for the multi-waveform generator: shared widths, register indexes,
// waveform codes and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mwg_pkg;

    localparam int unsigned MWG_SINE_TABLE_DEPTH = 256;
    localparam int unsigned MWG_PHASE_BITS       = 32;
    localparam int unsigned MWG_SAMPLE_BITS      = 16;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned WAVE_W      = 2;
    localparam int unsigned STEP_W      = 32;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned VOL_W       = 15;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned QUOT_W      = 32;
    localparam int unsigned ENTRY_W     = 16;

    localparam logic [ENTRY_W-1:0] FULL_SCALE     = 16'd32767;
    localparam logic [VOL_W-1:0]   VOLUME_RESET   = 15'd16384;
    localparam logic [HALF_W-1:0]  HALF_PER_RESET = 16'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_TYPE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME      = 2'd3;

    // Waveform codes.
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

    // Operand selection for the shared multiplier.
    localparam logic [1:0] MUL_IDX = 2'd0;
    localparam logic [1:0] MUL_AMP = 2'd1;
    localparam logic [1:0] MUL_CNT = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       mul_step;
        logic       rom_read;
        logic       div_start;
        logic       div_step;
        logic       finish;
    } mwg_cmd_t;

    typedef struct packed {
        logic              enable;
        logic [WAVE_W-1:0] wave_type;
        logic              mul_done;
        logic              div_done;
        logic              out_free;
    } mwg_status_t;

endpackage

`default_nettype wire

// ----- sv/mwg_ctrl.sv -----
// Sequencing controller of the multi-waveform generator.
// Depends on mwg_pkg; drives mwg_datapath through mwg_cmd_t and reads mwg_status_t.
`timescale 1ns / 1ps
`default_nettype none

module mwg_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire mwg_pkg::mwg_status_t status,
    output mwg_pkg::mwg_cmd_t        cmd
);
    import mwg_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_MUL_IDX   = 4'd2;
    localparam logic [3:0] S_ROM       = 4'd3;
    localparam logic [3:0] S_AMP_START = 4'd4;
    localparam logic [3:0] S_MUL_AMP   = 4'd5;
    localparam logic [3:0] S_MUL_CNT   = 4'd6;
    localparam logic [3:0] S_DIV       = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!status.enable || status.wave_type == WAVE_SQUARE) begin
                    state_next = S_FINISH;
                end else if (status.wave_type == WAVE_SINE) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_IDX;
                    state_next    = S_MUL_IDX;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_CNT;
                    state_next    = S_MUL_CNT;
                end
            end
            S_MUL_IDX: begin
                if (status.mul_done) begin
                    state_next = S_ROM;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_ROM: begin
                cmd.rom_read = 1'b1;
                state_next   = S_AMP_START;
            end
            S_AMP_START: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_AMP;
                state_next    = S_MUL_AMP;
            end
            S_MUL_AMP: begin
                if (status.mul_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_MUL_CNT: begin
                if (status.mul_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FINISH: begin
                // The result waits here until the output register is free.
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mwg_datapath.sv -----
// Datapath of the multi-waveform generator: configuration registers, phase
// accumulator, sample counter, sine table, shift-add multiplier, restoring divider
// and output register. Depends on mwg_pkg; sequenced by mwg_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mwg_datapath #(
    parameter int unsigned SINE_TABLE_DEPTH = mwg_pkg::MWG_SINE_TABLE_DEPTH,
    parameter int unsigned PHASE_BITS       = mwg_pkg::MWG_PHASE_BITS,
    parameter int unsigned SAMPLE_BITS      = mwg_pkg::MWG_SAMPLE_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [mwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_enable,
    input  wire logic                            s_block_end,
    input  wire mwg_pkg::mwg_cmd_t               cmd,
    output mwg_pkg::mwg_status_t                 status,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [SAMPLE_BITS-1:0]               m_sample,
    output logic                                 m_tlast
);
    import mwg_pkg::*;

    localparam int unsigned AW   = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned DW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned MB   = (DW > VOL_W) ? DW : VOL_W;
    localparam int unsigned MA   = (PHASE_BITS - 2 > COUNT_W) ? PHASE_BITS - 2 : COUNT_W;
    localparam int unsigned PW   = MA + MB;
    localparam int unsigned MCW  = $clog2(MB + 1);
    localparam int unsigned DCW  = $clog2(QUOT_W + 1);
    localparam int unsigned P_UP = (PHASE_BITS >= STEP_W) ? PHASE_BITS - STEP_W : 0;
    localparam int unsigned P_DN = (PHASE_BITS < STEP_W) ? STEP_W - PHASE_BITS : 0;
    localparam int unsigned S_UP = (SAMPLE_BITS >= ENTRY_W) ? SAMPLE_BITS - ENTRY_W : 0;
    localparam int unsigned S_DN = (SAMPLE_BITS < ENTRY_W) ? ENTRY_W - SAMPLE_BITS : 0;
    localparam logic [DW-1:0] DEPTH_IDX = DW'(SINE_TABLE_DEPTH);

    // Quarter-wave sine entry k: Q30 Taylor series to the x^13 term, terms truncated,
    // rounded half up to Q0.15 and capped at full scale. Evaluated at elaboration.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned val;
        x    = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        val  = (sum * 64'd32767 + 64'd536870912) >> 30;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        return ENTRY_W'(val);
    endfunction

    // Configuration registers.
    logic [WAVE_W-1:0]     wave_type_reg;
    logic [STEP_W-1:0]     phase_step_reg;
    logic [HALF_W-1:0]     half_period_reg;
    logic [VOL_W-1:0]      volume_reg;

    // Item state.
    logic                  enable_reg;
    logic                  block_end_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    // Multiplier.
    logic [PW-1:0]         mul_a_reg;
    logic [MB-1:0]         mul_b_reg;
    logic [PW-1:0]         prod_reg;
    logic [MCW-1:0]        mul_cnt_reg;
    logic [PW-1:0]         mul_a_next;
    logic [MB-1:0]         mul_b_next;

    // Divider.
    logic [QUOT_W-1:0]     dn_reg;
    logic [COUNT_W-1:0]    dd_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DCW-1:0]        div_cnt_reg;
    logic [COUNT_W:0]      trial;
    logic                  trial_ge;

    // Sine table.
    logic [ENTRY_W-1:0]    sine_rom [SINE_TABLE_DEPTH];
    logic [ENTRY_W-1:0]    rom_q_reg;
    logic                  full_reg;
    logic [DW-1:0]         idx_raw;
    logic [DW-1:0]         idx_sel;
    logic                  idx_full;
    logic [AW-1:0]         rom_addr;
    logic [ENTRY_W-1:0]    entry;

    // Derived values.
    logic [HALF_W-1:0]     h_eff;
    logic [COUNT_W-1:0]    h2;
    logic                  c_le_h;
    logic [COUNT_W-1:0]    down_cnt;
    logic [COUNT_W:0]      count_inc;
    logic [1:0]            quad;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [79:0]           step_wide;
    logic [30:0]           amp_round;
    logic [QUOT_W-1:0]     mag;
    logic [39:0]           mag_wide;
    logic [SAMPLE_BITS-1:0] mag_out;
    logic                  negative;
    logic [SAMPLE_BITS-1:0] sample_next;

    logic                  m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    logic                  m_tlast_reg;

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    // ---------------------------------------------------------------------
    // Combinational helpers.
    // ---------------------------------------------------------------------
    assign h_eff     = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;
    assign h2        = {h_eff, 1'b0};
    assign c_le_h    = (count_reg <= {1'b0, h_eff});
    assign down_cnt  = (count_reg < h2) ? (h2 - count_reg) : '0;
    assign count_inc = {1'b0, count_reg} + (COUNT_W + 1)'(1);
    assign quad      = phase_acc_reg[PHASE_BITS-1 -: 2];
    assign step_wide = (80'(phase_step_reg) << P_UP) >> P_DN;
    assign phase_inc = PHASE_BITS'(step_wide);

    // Table index from the phase product; odd quadrants read the table backwards.
    assign idx_raw  = prod_reg[PHASE_BITS-2 +: DW];
    assign idx_sel  = quad[0] ? (DEPTH_IDX - idx_raw) : idx_raw;
    assign idx_full = (idx_sel == DEPTH_IDX);
    assign rom_addr = idx_full ? '0 : idx_sel[AW-1:0];
    assign entry    = full_reg ? FULL_SCALE : rom_q_reg;

    assign trial    = {rem_reg, dn_reg[QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, dd_reg});

    assign amp_round = {1'b0, prod_reg[29:0]} + 31'd16384;

    always_comb begin
        if (!enable_reg) begin
            mag = '0;
        end else begin
            case (wave_type_reg)
                WAVE_SINE:   mag = QUOT_W'(amp_round[30:15]);
                WAVE_SQUARE: mag = c_le_h ? QUOT_W'(volume_reg) : '0;
                default:     mag = dn_reg;
            endcase
        end
    end

    assign negative    = enable_reg && (wave_type_reg == WAVE_SINE) && quad[1];
    assign mag_wide    = (40'(mag) << S_UP) >> S_DN;
    assign mag_out     = SAMPLE_BITS'(mag_wide);
    assign sample_next = negative ? (SAMPLE_BITS'(0) - mag_out) : mag_out;

    always_comb begin
        phase_acc_next = phase_acc_reg;
        count_next     = count_reg;
        if (!enable_reg) begin
            phase_acc_next = '0;
            count_next     = '0;
        end else if (wave_type_reg == WAVE_SINE) begin
            phase_acc_next = phase_acc_reg + phase_inc;
        end else if (count_inc >= {1'b0, h2}) begin
            count_next = '0;
        end else begin
            count_next = count_inc[COUNT_W-1:0];
        end
    end

    always_comb begin
        mul_a_next = '0;
        mul_b_next = '0;
        case (cmd.mul_sel)
            MUL_IDX: begin
                mul_a_next = PW'(phase_acc_reg[PHASE_BITS-3:0]);
                mul_b_next = MB'(SINE_TABLE_DEPTH);
            end
            MUL_AMP: begin
                mul_a_next = PW'(entry);
                mul_b_next = MB'(volume_reg);
            end
            MUL_CNT: begin
                mul_a_next = (wave_type_reg == WAVE_TRIANGLE && !c_le_h) ?
                             PW'(down_cnt) : PW'(count_reg);
                mul_b_next = MB'(volume_reg);
            end
            default: begin
                mul_a_next = '0;
                mul_b_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_type_reg   <= WAVE_SINE;
            phase_step_reg  <= '0;
            half_period_reg <= HALF_PER_RESET;
            volume_reg      <= VOLUME_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WAVE_TYPE:   wave_type_reg   <= cfg_wdata[WAVE_W-1:0];
                REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata[STEP_W-1:0];
                REG_HALF_PERIOD: half_period_reg <= cfg_wdata[HALF_W-1:0];
                REG_VOLUME:      volume_reg      <= cfg_wdata[VOL_W-1:0];
                default:         wave_type_reg   <= wave_type_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            count_reg     <= '0;
            enable_reg    <= 1'b0;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                enable_reg <= s_enable;
            end
            if (cmd.finish) begin
                phase_acc_reg <= phase_acc_next;
                count_reg     <= count_next;
            end
            if (cmd.mul_start) begin
                mul_cnt_reg <= MCW'(MB);
            end else if (cmd.mul_step) begin
                mul_cnt_reg <= mul_cnt_reg - MCW'(1);
            end
            if (cmd.div_start) begin
                div_cnt_reg <= DCW'(QUOT_W);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            block_end_reg <= s_block_end;
        end
        if (cmd.mul_start) begin
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            prod_reg  <= '0;
        end else if (cmd.mul_step) begin
            if (mul_b_reg[0]) begin
                prod_reg <= prod_reg + mul_a_reg;
            end
            mul_a_reg <= {mul_a_reg[PW-2:0], 1'b0};
            mul_b_reg <= {1'b0, mul_b_reg[MB-1:1]};
        end
        if (cmd.rom_read) begin
            rom_q_reg <= sine_rom[rom_addr];
            full_reg  <= idx_full;
        end
        if (cmd.div_start) begin
            dn_reg  <= prod_reg[QUOT_W-1:0];
            dd_reg  <= (wave_type_reg == WAVE_SAWTOOTH) ? h2 : {1'b0, h_eff};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            // Restoring division: the quotient bits shift in behind the dividend.
            rem_reg <= trial_ge ? COUNT_W'(trial - {1'b0, dd_reg}) : trial[COUNT_W-1:0];
            dn_reg  <= {dn_reg[QUOT_W-2:0], trial_ge};
        end
        if (cmd.finish) begin
            m_sample_reg <= sample_next;
            m_tlast_reg  <= block_end_reg;
        end
    end

    assign status.enable    = enable_reg;
    assign status.wave_type = wave_type_reg;
    assign status.mul_done  = (mul_cnt_reg == '0);
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_sample = m_sample_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- sv/multi_waveform_generator.sv -----
// Top level of the multi-waveform generator: sample tick stream in, audio sample out.
// Depends on mwg_pkg, mwg_ctrl and mwg_datapath.
//
//   Channel   Direction  Ports                                  Contents
//   s_        in         s_tvalid s_tready s_tdata s_tlast      enable, end of buffer
//   m_        out        m_tvalid m_tready m_tdata m_tlast      sample, end of buffer
//   cfg_      in         cfg_we cfg_index cfg_wdata             register writes
//
// Disabled and square requests go from the decide state straight to the finish state; sine
// requests run the shift-add multiplier (one bit per cycle) for the table index, read the
// table and run it again for the amplitude; sawtooth and triangle requests run it once, then
// the 32-step divider. The multiplier takes MB = max(15, table depth bit width) steps, 15 at defaults.
// Reset is synchronous and active low; the sine table is constant and needs no fill.
// A finished sample waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_generator #(
    parameter int unsigned SINE_TABLE_DEPTH = mwg_pkg::MWG_SINE_TABLE_DEPTH,
    parameter int unsigned PHASE_BITS       = mwg_pkg::MWG_PHASE_BITS,
    parameter int unsigned SAMPLE_BITS      = mwg_pkg::MWG_SAMPLE_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [mwg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [mwg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [7:0]                            s_tdata,   // [0] enable
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   m_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                                       m_tlast
);
    import mwg_pkg::*;

    localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    mwg_cmd_t               cmd;
    mwg_status_t            status;
    logic [SAMPLE_BITS-1:0] sample;

    mwg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mwg_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_enable    (s_tdata[0]),
        .s_block_end (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_sample    (sample),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = OUT_W'(sample);

endmodule

`default_nettype wire

// ----- dv/multi_waveform_generator_test.sv -----
// Self-checking testbench for multi_waveform_generator: random sample ticks and register
// settings, with every returned sample compared against an in-bench predictor.
// Depends on mwg_pkg and the multi_waveform_generator RTL.
`timescale 1ns / 1ps

module multi_waveform_generator_test;
    import mwg_pkg::*;

    localparam int unsigned TABLE_DEPTH     = MWG_SINE_TABLE_DEPTH;
    localparam int          IDLE_LIMIT      = 4000;
    localparam int          HOLD_OFF_CYCLES = 600;
    localparam int          TAIL_CYCLES     = 80;
    localparam int          TOTAL_TICKS     = 550;

    typedef struct packed {
        logic [MWG_SAMPLE_BITS-1:0] sample;
        logic                       block_end;
    } sample_t;

    // Tracks the generator state and holds the samples still owed by the block.
    class sample_tracker;
        logic [ENTRY_W-1:0]        sine_rom [TABLE_DEPTH];
        logic [WAVE_W-1:0]         wave;
        logic [STEP_W-1:0]         step;
        logic [HALF_W-1:0]         half;
        logic [VOL_W-1:0]          vol;
        logic [MWG_PHASE_BITS-1:0] phase;
        logic [COUNT_W-1:0]        count;
        sample_t                   pending_samples[$];
        int                        errors;
        int                        checked;
        int                        silent;
        int                        writes;
        int                        per_wave[4];

        function new();
            longint unsigned x, x2, term, sum, val;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                // Taylor series of sin in Q30, truncated terms, rounded half up at the end.
                x = 64'd1686629713 * k / TABLE_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                val = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
                if (val > FULL_SCALE)
                    val = FULL_SCALE;
                sine_rom[k] = val[ENTRY_W-1:0];
            end
            wave = WAVE_SINE;
            step = '0;
            half = HALF_PER_RESET;
            vol = VOLUME_RESET;
            phase = '0;
            count = '0;
            errors = 0;
            checked = 0;
            silent = 0;
            writes = 0;
            for (int w = 0; w < 4; w++)
                per_wave[w] = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_WAVE_TYPE:   wave = value[WAVE_W-1:0];
                REG_PHASE_STEP:  step = value[STEP_W-1:0];
                REG_HALF_PERIOD: half = value[HALF_W-1:0];
                REG_VOLUME:      vol = value[VOL_W-1:0];
                default: ;
            endcase
            writes++;
        endfunction

        function void take_tick(bit en, bit last_flag);
            sample_t         exp_s;
            longint unsigned mag, h, c, v, down, rest, idx;
            bit              negative;
            mag = 0;
            negative = 0;
            exp_s.block_end = last_flag;
            if (!en) begin
                phase = '0;
                count = '0;
                silent++;
            end else if (wave == WAVE_SINE) begin
                // Odd quadrants read the table backwards; the top quadrants are negated.
                rest = phase[MWG_PHASE_BITS-3:0];
                idx = (rest * TABLE_DEPTH) >> (MWG_PHASE_BITS - 2);
                if (phase[MWG_PHASE_BITS-2])
                    idx = TABLE_DEPTH - idx;
                mag = (idx >= TABLE_DEPTH) ? FULL_SCALE : sine_rom[idx];
                mag = (mag * vol + 64'd16384) >> 15;
                negative = phase[MWG_PHASE_BITS-1];
                phase = phase + step;
                per_wave[wave]++;
            end else begin
                h = (half == 0) ? 1 : half;
                c = count;
                v = vol;
                case (wave)
                    WAVE_SQUARE:   mag = (c <= h) ? v : 0;
                    WAVE_SAWTOOTH: mag = (v * c) / (2 * h);
                    default: begin
                        if (c <= h) begin
                            mag = (v * c) / h;
                        end else begin
                            // A count left beyond the period by a shorter half period gives 0.
                            down = (c < 2 * h) ? (2 * h - c) : 0;
                            mag = (v * down) / h;
                        end
                    end
                endcase
                c = c + 1;
                if (c >= 2 * h)
                    c = 0;
                count = c[COUNT_W-1:0];
                per_wave[wave]++;
            end
            if (negative)
                exp_s.sample = '0 - mag[MWG_SAMPLE_BITS-1:0];
            else
                exp_s.sample = mag[MWG_SAMPLE_BITS-1:0];
            pending_samples.push_back(exp_s);
        endfunction

        function void check_sample(logic [MWG_SAMPLE_BITS-1:0] got_s, logic got_l);
            sample_t exp_s;
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample %0d last %b with no request outstanding",
                         $time, $signed(got_s), got_l);
                return;
            end
            exp_s = pending_samples.pop_front();
            checked++;
            if (got_s !== exp_s.sample) begin
                errors++;
                $display("%0t: sample mismatch: expected %0d, actual %0d", $time,
                         $signed(exp_s.sample), $signed(got_s));
            end
            if (got_l !== exp_s.block_end) begin
                errors++;
                $display("%0t: end-of-buffer mismatch: expected %b, actual %b", $time,
                         exp_s.block_end, got_l);
            end
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;    // [0] enable
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [15:0]                m_tdata;    // [15:0] sample
    logic                       m_tlast;

    sample_tracker tracker;
    bit            calm = 1'b0;
    bit            hold_off_req = 1'b0;
    int            hold_offs = 0;
    int            ticks_sent = 0;
    int            idle_cycles = 0;

    multi_waveform_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic send_tick(bit en, bit last_flag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, en};
        s_tlast <= last_flag;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        tracker.take_tick(en, last_flag);
        ticks_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(index, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return 32'h8000_0000;
        else if (r < 12)
            return $urandom_range(1, 32'h0400_0000);
        else
            return $urandom;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_half();
        logic [15:0] upper;
        logic [15:0] h;
        int          r;
        upper = 16'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0)
            h = '0;
        else if (r == 1)
            h = 16'hFFFF;
        else if (r < 14)
            h = 16'($urandom_range(1, 20));
        else if (r < 19)
            h = 16'($urandom_range(21, 300));
        else
            h = 16'($urandom);
        return {upper, h};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_volume();
        logic [16:0] upper;
        logic [14:0] v;
        int          r;
        upper = 17'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = 15'h7FFF;
        else
            v = 15'($urandom);
        return {upper, v};
    endfunction

    initial begin : stimulus
        int  phase_len;
        bit  first_phase;
        bit  pressure_done;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_WAVE_TYPE;
        cfg_wdata <= '0;
        tracker = new();
        first_phase = 1'b1;
        pressure_done = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, then a silent tick that ends a buffer.
        send_tick(1, 0);
        send_tick(0, 1);

        // Quarter-turn steps at full volume visit every quadrant boundary, including
        // the entry one past the end of the table and the most negative sample.
        wait_idle();
        write_reg(REG_VOLUME, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        repeat (5) send_tick(1, 0);

        wait_idle();
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        write_reg(REG_VOLUME, 32'h0000_0000);
        send_tick(1, 0);
        send_tick(1, 1);

        // Square with a zero half period, which behaves as one; upper bits are dropped.
        wait_idle();
        write_reg(REG_WAVE_TYPE, 32'hFFFF_FFFD);
        write_reg(REG_HALF_PERIOD, 32'h0000_0000);
        write_reg(REG_VOLUME, 32'h0000_7FFF);
        repeat (3) send_tick(1, 0);

        wait_idle();
        write_reg(REG_WAVE_TYPE, WAVE_TRIANGLE);
        write_reg(REG_HALF_PERIOD, 32'd6);
        repeat (8) send_tick(1, 0);
        send_tick(1, 1);

        // Shrinking the half period leaves the count beyond the new period.
        wait_idle();
        write_reg(REG_HALF_PERIOD, 32'hABCD_0002);
        repeat (2) send_tick(1, 0);

        wait_idle();
        write_reg(REG_WAVE_TYPE, WAVE_SAWTOOTH);
        write_reg(REG_HALF_PERIOD, 32'h0000_FFFF);
        send_tick(1, 0);
        send_tick(1, 1);

        while (ticks_sent < TOTAL_TICKS) begin
            wait_idle();
            if (first_phase || $urandom_range(0, 9) < 6)
                write_reg(REG_WAVE_TYPE, $urandom);
            if (first_phase || $urandom_range(0, 9) < 4)
                write_reg(REG_PHASE_STEP, pick_step());
            if (first_phase || $urandom_range(0, 9) < 5)
                write_reg(REG_HALF_PERIOD, pick_half());
            if (first_phase || $urandom_range(0, 9) < 4)
                write_reg(REG_VOLUME, pick_volume());
            first_phase = 1'b0;
            calm = ($urandom_range(0, 5) == 0);
            phase_len = $urandom_range(8, 40);
            if (!pressure_done && ticks_sent > 250) begin
                // The receiver stops for a long while and the sender keeps pushing.
                calm = 1'b1;
                hold_off_req = 1'b1;
                pressure_done = 1'b1;
                phase_len = 24;
            end
            repeat (phase_len)
                send_tick($urandom_range(0, 15) != 0, $urandom_range(0, 7) == 0);
            calm = 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d samples: %0d sine, %0d square, %0d sawtooth, %0d triangle, %0d silent.",
                 tracker.checked, tracker.per_wave[WAVE_SINE], tracker.per_wave[WAVE_SQUARE],
                 tracker.per_wave[WAVE_SAWTOOTH], tracker.per_wave[WAVE_TRIANGLE],
                 tracker.silent);
        $display("%0d register writes, %0d receiver hold-off(s), %0d error(s).",
                 tracker.writes, hold_offs, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("multi_waveform_generator verification clean");
        else
            $display("multi_waveform_generator verification failed");
        $finish;
    end

    initial begin : ready_driver
        int stall;
        int burst;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_sample(m_tdata[15:0], m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles, %0d sample(s) outstanding",
                     $time, IDLE_LIMIT, tracker.pending());
            $display("multi_waveform_generator verification failed");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
sv/mwg_pkg.sv
sv/mwg_ctrl.sv
sv/mwg_datapath.sv
sv/multi_waveform_generator.sv
dv/multi_waveform_generator_test.sv
